// ===== sv/modbus_tcp_client_transaction_top_macros.svh =====
`ifndef MODBUS_TCP_CLIENT_TRANSACTION_TOP_MACROS_SVH
`define MODBUS_TCP_CLIENT_TRANSACTION_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define MTC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define MTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/mtc_pkg.sv =====
package mtc_pkg;

    localparam int HEADER_BYTES = 7;
    localparam int FRAME_BYTES  = 12;
    localparam int IN_DATA_W    = 56;
    localparam int OUT_DATA_W   = 32;

    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_RX_BYTE = 1'b1;

    localparam logic KIND_TX      = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam logic [7:0] FN_READ_HOLDING = 8'h03;
    localparam logic [7:0] FN_READ_INPUT   = 8'h04;
    localparam logic [7:0] FN_WRITE_SINGLE = 8'h06;
    localparam logic [7:0] FN_EXCEPTION    = 8'h80;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_ID       = 3'd1,
        ST_PROTOCOL = 3'd2,
        ST_EXCEPT   = 3'd3,
        ST_COUNT    = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        STEP_HEADER = 3'b001,
        STEP_META   = 3'b010,
        STEP_DATA   = 3'b100
    } t_step;

    // fields from the msb down; unit_id sits in the lowest bits
    typedef struct packed {
        logic [7:0]  rx_byte;
        logic [15:0] write_value;
        logic [15:0] register_address;
        logic [7:0]  function_code;
        logic [7:0]  unit_id;
    } t_in_data;

    typedef struct packed {
        logic [4:0]  pad;
        logic [15:0] register_value;
        t_status     status;
        logic [7:0]  tx_byte;
    } t_out_data;

    function automatic logic is_read(input logic [7:0] fn);
        return (fn == FN_READ_HOLDING) || (fn == FN_READ_INPUT);
    endfunction

    function automatic logic [7:0] frame_byte(
        input logic [3:0]  idx,
        input logic [15:0] tid,
        input logic [7:0]  unit,
        input logic [7:0]  fn,
        input logic [15:0] addr,
        input logic [15:0] cnt
    );
        logic [7:0] b;
        case (idx)
            4'd0:    b = tid[15:8];
            4'd1:    b = tid[7:0];
            4'd5:    b = 8'd6;
            4'd6:    b = unit;
            4'd7:    b = fn;
            4'd8:    b = addr[15:8];
            4'd9:    b = addr[7:0];
            4'd10:   b = cnt[15:8];
            4'd11:   b = cnt[7:0];
            default: b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

// ===== sv/modbus_tcp_client_transaction_top.sv =====
// modbus tcp client transaction engine
// input stream: s_axis_tuser selects the transaction type. 0 issues a request
// (unit, function, address, write value in tdata), 1 delivers one received
// response byte (rx_byte in tdata).
// output stream: m_axis_tuser 0 carries a request frame byte in tdata with
// tlast on the twelfth byte; m_axis_tuser 1 carries the response verdict
// (status and first register value).
// a request bumps the 16-bit transaction id and yields 12 frame bytes, one per
// cycle unless the receiver stalls; the first appears in the cycle after it is
// accepted. the frame sequencer holds tready low while it runs, until it has
// registered the last byte. a response byte is parsed in the cycle it is taken,
// one byte per cycle while tready is high; the final byte registers the verdict.
// the output register lets the next transaction enter while a result waits;
// when the receiver stalls, tready drops only once that register is full.
// a request arriving mid-response drops the partial response.
// reset (synchronous, active low) clears the id to 0, rearms the parser and
// empties the output register.
module modbus_tcp_client_transaction_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // unit_id, function_code, register_address, write_value, rx_byte
    input  logic [mtc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // op
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tx_byte, status, register_value, zero fill
    output logic [mtc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // kind
    output logic                            m_axis_tuser,
    output logic                            m_axis_tlast
);
    import mtc_pkg::*;

    `include "modbus_tcp_client_transaction_top_macros.svh"

    localparam logic [8:0] POS_MAX    = 9'd511;
    localparam logic [8:0] REM_RESET  = 9'(HEADER_BYTES + 1);
    localparam logic [8:0] DATA_START = 9'(HEADER_BYTES + 2);
    localparam logic [3:0] LAST_IDX   = 4'(FRAME_BYTES - 1);

    t_in_data    w_in;
    logic        w_slot;
    logic        w_acc;
    logic        w_acc_req;
    logic        w_acc_rx;

    logic [15:0] r_tid, n_tid;
    logic [7:0]  r_unit;
    logic [7:0]  r_req_fn;
    logic [15:0] r_addr;
    logic [15:0] r_req_cnt, n_req_cnt;
    logic        r_busy;
    logic [3:0]  r_idx;

    t_step       r_step, n_step;
    logic [8:0]  r_rem, n_rem;
    logic [8:0]  r_pos, n_pos;
    logic [8:0]  w_dpos;
    logic [15:0] r_rid, n_rid;
    logic [15:0] r_proto, n_proto;
    logic [7:0]  r_rfn, n_rfn;
    logic [7:0]  r_bcnt, n_bcnt;
    logic [15:0] r_fdw, n_fdw;
    logic        w_done;
    t_status     w_status;
    logic [15:0] w_value;

    logic        r_out_valid;
    logic        r_out_kind;
    logic        r_out_last;
    logic [7:0]  r_out_tx;
    t_status     r_out_status;
    logic [15:0] r_out_value;
    t_out_data   w_out;

    assign w_in          = t_in_data'(s_axis_tdata);
    assign w_slot        = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_busy && w_slot;
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign w_acc_req     = w_acc && (s_axis_tuser == OP_REQUEST);
    assign w_acc_rx      = w_acc && (s_axis_tuser == OP_RX_BYTE);

    assign n_tid     = r_tid + 16'd1;
    assign n_req_cnt = is_read(w_in.function_code) ? 16'd1 : w_in.write_value;

    // response byte parser
    always_comb begin
        n_rid   = r_rid;
        n_proto = r_proto;
        n_rfn   = r_rfn;
        n_bcnt  = r_bcnt;
        n_fdw   = r_fdw;
        n_step  = r_step;
        w_done  = 1'b0;
        w_dpos  = r_pos - DATA_START;
        n_pos   = (r_pos != POS_MAX) ? r_pos + 9'd1 : r_pos;
        n_rem   = (r_rem != 9'd0) ? r_rem - 9'd1 : r_rem;
        case (r_step)
            STEP_HEADER: begin
                if (r_pos == 9'd0) n_rid[15:8] = w_in.rx_byte;
                if (r_pos == 9'd1) n_rid[7:0] = w_in.rx_byte;
                if (r_pos == 9'd2) n_proto[15:8] = w_in.rx_byte;
                if (r_pos == 9'd3) n_proto[7:0] = w_in.rx_byte;
                if (r_pos == 9'(HEADER_BYTES)) n_rfn = w_in.rx_byte;
            end
            STEP_META: begin
                if (r_pos == 9'(HEADER_BYTES + 1)) n_bcnt = w_in.rx_byte;
            end
            STEP_DATA: begin
                if (w_dpos == 9'd0) n_fdw[15:8] = w_in.rx_byte;
                if (w_dpos == 9'd1) n_fdw[7:0] = w_in.rx_byte;
            end
            default: ;
        endcase
        if (n_rem == 9'd0) begin
            case (r_step)
                STEP_HEADER: begin
                    n_rem  = (n_rfn == FN_WRITE_SINGLE) ? 9'd4 : 9'd1;
                    n_step = STEP_META;
                end
                STEP_META: begin
                    if (is_read(n_rfn) && (n_bcnt != 8'd0)) begin
                        n_rem  = {1'b0, n_bcnt};
                        n_step = STEP_DATA;
                    end else begin
                        w_done = 1'b1;
                    end
                end
                default: w_done = 1'b1;
            endcase
        end
    end

    // verdict, checks in priority order
    always_comb begin
        if (n_rid != r_tid) begin
            w_status = ST_ID;
        end else if (n_proto != 16'd0) begin
            w_status = ST_PROTOCOL;
        end else if (n_rfn >= FN_EXCEPTION) begin
            w_status = ST_EXCEPT;
        end else if (is_read(n_rfn) && (r_req_cnt != {9'd0, n_bcnt[7:1]})) begin
            w_status = ST_COUNT;
        end else begin
            w_status = ST_OK;
        end
        w_value = ((w_status == ST_OK) && is_read(n_rfn)) ? n_fdw : 16'd0;
    end

    // request state and frame sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tid     <= 16'd0;
            r_req_fn  <= 8'd0;
            r_req_cnt <= 16'd0;
            r_busy    <= 1'b0;
            r_idx     <= 4'd0;
        end else if (r_busy) begin
            if (w_slot) begin
                r_idx <= r_idx + 4'd1;
                if (r_idx == LAST_IDX) r_busy <= 1'b0;
            end
        end else if (w_acc_req) begin
            r_tid     <= n_tid;
            r_req_fn  <= w_in.function_code;
            r_req_cnt <= n_req_cnt;
            r_busy    <= 1'b1;
            r_idx     <= 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc_req) begin
            r_unit <= w_in.unit_id;
            r_addr <= w_in.register_address;
        end
    end

    // response parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_acc_req || (w_acc_rx && w_done)) begin
            r_step  <= STEP_HEADER;
            r_rem   <= REM_RESET;
            r_pos   <= 9'd0;
            r_rid   <= 16'd0;
            r_proto <= 16'd0;
            r_rfn   <= 8'd0;
            r_bcnt  <= 8'd0;
            r_fdw   <= 16'd0;
        end else if (w_acc_rx) begin
            r_step  <= n_step;
            r_rem   <= n_rem;
            r_pos   <= n_pos;
            r_rid   <= n_rid;
            r_proto <= n_proto;
            r_rfn   <= n_rfn;
            r_bcnt  <= n_bcnt;
            r_fdw   <= n_fdw;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_busy && w_slot) begin
            r_out_valid <= 1'b1;
        end else if (w_acc_req || (w_acc_rx && w_done)) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy && w_slot) begin
            r_out_kind   <= KIND_TX;
            r_out_tx     <= frame_byte(r_idx, r_tid, r_unit, r_req_fn, r_addr, r_req_cnt);
            r_out_last   <= (r_idx == LAST_IDX);
            r_out_status <= ST_OK;
            r_out_value  <= 16'd0;
        end else if (w_acc_req) begin
            r_out_kind   <= KIND_TX;
            r_out_tx     <= n_tid[15:8];
            r_out_last   <= 1'b0;
            r_out_status <= ST_OK;
            r_out_value  <= 16'd0;
        end else if (w_acc_rx && w_done) begin
            r_out_kind   <= KIND_VERDICT;
            r_out_tx     <= 8'd0;
            r_out_last   <= 1'b0;
            r_out_status <= w_status;
            r_out_value  <= w_value;
        end
    end

    always_comb begin
        w_out                = '0;
        w_out.tx_byte        = r_out_tx;
        w_out.status         = r_out_status;
        w_out.register_value = r_out_value;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DATA_W'(w_out);
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

    `MTC_ASSERT_NEXT(a_req_starts_frame, i_clk, i_rst_n, w_acc_req,
        r_busy && (r_idx == 4'd1) && r_out_valid && (r_out_kind == KIND_TX)
        && (r_out_tx == r_tid[15:8]), "request did not start its frame")
    `MTC_ASSERT_NOW(a_last_ends_frame, i_clk, i_rst_n, r_out_valid && r_out_last,
        (r_out_kind == KIND_TX) && !r_busy, "frame end mark while sequencer busy")
    `MTC_ASSERT_NOW(a_header_pos, i_clk, i_rst_n, r_step == STEP_HEADER,
        r_pos <= 9'(HEADER_BYTES), "header step past function byte")
    `MTC_ASSERT_NOW(a_bad_verdict_no_value, i_clk, i_rst_n,
        r_out_valid && (r_out_kind == KIND_VERDICT) && (r_out_status != ST_OK),
        r_out_value == 16'd0, "failed verdict carries a register value")
    `MTC_ASSERT_NOW(a_busy_blocks_input, i_clk, i_rst_n, r_busy && (r_idx == 4'd0),
        1'b0, "frame sequencer busy with index zero")

endmodule
